// ===== sv/array_linear_interpolator_assert.svh =====
// Assertion macros shared by the interpolator checker.
// Depends on nothing; included by the checker file only.
`ifndef ARRAY_LINEAR_INTERPOLATOR_ASSERT_SVH
`define ARRAY_LINEAR_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interpolator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ALI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interpolator assertion failed");

`endif

// ===== sv/ali_pkg.sv =====
// Shared widths, register indexes and types of the array linear interpolator.
// Used by the weight generator, the top level and the checker.
package ali_pkg;

    localparam int SAMPLE_WIDTH     = 16;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_INT_BITS  = 6;
    localparam int WEIGHT_WIDTH     = WEIGHT_FRAC_BITS + WEIGHT_INT_BITS;
    localparam int ABSC_WIDTH       = 16;

    // Datapath widths.
    localparam int DIFF_WIDTH = SAMPLE_WIDTH + 1;
    localparam int PROD_WIDTH = WEIGHT_WIDTH + DIFF_WIDTH;
    localparam int ACC_WIDTH  = PROD_WIDTH + 1;
    localparam int YW_WIDTH   = ACC_WIDTH - WEIGHT_FRAC_BITS;

    // Divider widths: magnitude of a span fits ABSC_WIDTH unsigned bits.
    localparam int QUOT_WIDTH = ABSC_WIDTH + WEIGHT_FRAC_BITS + 1;
    localparam int CNT_WIDTH  = $clog2(QUOT_WIDTH);

    // Stream and register port widths.
    localparam int IN_TDATA_WIDTH   = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_WIDTH  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_TUSER_WIDTH  = 2;
    localparam int TUSER_EXTRAP     = 0;
    localparam int TUSER_CLIP       = 1;
    localparam int APB_DATA_WIDTH   = 32;
    localparam int CFG_ADDR_WIDTH   = 4;
    localparam int REG_IDX_WIDTH    = CFG_ADDR_WIDTH - 2;

    localparam logic [REG_IDX_WIDTH-1:0] REG_LEFT   = REG_IDX_WIDTH'(0);
    localparam logic [REG_IDX_WIDTH-1:0] REG_RIGHT  = REG_IDX_WIDTH'(1);
    localparam logic [REG_IDX_WIDTH-1:0] REG_TARGET = REG_IDX_WIDTH'(2);

    typedef enum logic [1:0] {
        WG_IDLE,
        WG_LOAD,
        WG_DIV,
        WG_FIN
    } t_wg_state;

    // Per-configuration settings handed from the weight generator to the datapath.
    typedef struct packed {
        logic signed [WEIGHT_WIDTH-1:0] weight;
        logic                           copy_mode;
        logic                           swapped;
        logic                           outside;
        logic                           sat;
    } t_wcfg;

endpackage

// ===== sv/ali_wgen.sv =====
// Configuration registers and weight generator with a bit-serial divider.
// Depends on ali_pkg.
module ali_wgen (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [ali_pkg::CFG_ADDR_WIDTH-1:0]  i_paddr,
    input  logic [ali_pkg::APB_DATA_WIDTH-1:0]  i_pwdata,
    output logic [ali_pkg::APB_DATA_WIDTH-1:0]  o_prdata,
    output logic                                o_busy,
    output ali_pkg::t_wcfg                      o_wcfg
);

    localparam int AW = ali_pkg::ABSC_WIDTH;
    localparam int QW = ali_pkg::QUOT_WIDTH;
    localparam int WW = ali_pkg::WEIGHT_WIDTH;
    localparam int DW = ali_pkg::APB_DATA_WIDTH;

    logic                                   wr;
    logic                                   wr_hit;
    logic [ali_pkg::REG_IDX_WIDTH-1:0]      idx;

    logic signed [AW-1:0]                   r_left;
    logic signed [AW-1:0]                   r_right;
    logic signed [AW-1:0]                   r_target;

    ali_pkg::t_wg_state                     r_state;
    ali_pkg::t_wg_state                     n_state;
    logic                                   load_en;
    logic                                   div_en;
    logic                                   fin_en;

    // Setup values derived from the registers.
    logic                                   s_copy;
    logic                                   s_swap;
    logic signed [AW-1:0]                   s_lo;
    logic signed [AW-1:0]                   s_hi;
    logic                                   s_outside;
    logic signed [AW:0]                     s_num;
    logic signed [AW:0]                     s_neg_num;
    logic signed [AW:0]                     s_den;
    logic [AW-1:0]                          s_mag;

    // Divider.
    logic [AW-1:0]                          r_den;
    logic [AW-1:0]                          r_rem;
    logic [QW-1:0]                          r_quot;
    logic                                   r_neg;
    logic [ali_pkg::CNT_WIDTH-1:0]          r_cnt;
    logic [AW:0]                            rem_sh;
    logic [AW+1:0]                          rem_diff;
    logic                                   rem_ge;

    // Final rounding and saturation.
    logic [QW:0]                            q_inc;
    logic [QW-1:0]                          q_rnd;
    logic                                   q_big;
    logic                                   q_is_min;
    logic                                   w_sat;
    logic signed [WW-1:0]                   w_val;

    ali_pkg::t_wcfg                         r_wcfg;

    assign wr     = i_psel && i_penable && i_pwrite;
    assign idx    = i_paddr[ali_pkg::CFG_ADDR_WIDTH-1:2];
    assign wr_hit = wr && ((idx == ali_pkg::REG_LEFT) || (idx == ali_pkg::REG_RIGHT)
                           || (idx == ali_pkg::REG_TARGET));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_right  <= '0;
            r_target <= '0;
        end else if (wr) begin
            case (idx)
                ali_pkg::REG_LEFT:   r_left   <= i_pwdata[AW-1:0];
                ali_pkg::REG_RIGHT:  r_right  <= i_pwdata[AW-1:0];
                ali_pkg::REG_TARGET: r_target <= i_pwdata[AW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            ali_pkg::REG_LEFT:   o_prdata = {{(DW-AW){r_left[AW-1]}}, r_left};
            ali_pkg::REG_RIGHT:  o_prdata = {{(DW-AW){r_right[AW-1]}}, r_right};
            ali_pkg::REG_TARGET: o_prdata = {{(DW-AW){r_target[AW-1]}}, r_target};
            default:             o_prdata = '0;
        endcase
    end

    always_comb begin
        s_copy    = (r_left == r_right);
        s_swap    = (r_left > r_right);
        s_lo      = s_swap ? r_right : r_left;
        s_hi      = s_swap ? r_left  : r_right;
        s_outside = (r_target > s_hi) || (r_target < s_lo);
        s_num     = {s_hi[AW-1], s_hi} - {r_target[AW-1], r_target};
        s_neg_num = -s_num;
        s_mag     = s_num[AW] ? s_neg_num[AW-1:0] : s_num[AW-1:0];
        s_den     = {s_hi[AW-1], s_hi} - {s_lo[AW-1], s_lo};
    end

    // One quotient bit per cycle, most significant first.
    always_comb begin
        rem_sh   = {r_rem, r_quot[QW-1]};
        rem_diff = {1'b0, rem_sh} - {2'b00, r_den};
        rem_ge   = !rem_diff[AW+1];
    end

    always_comb begin
        q_inc    = {1'b0, r_quot} + (QW+1)'(1);
        q_rnd    = q_inc[QW:1];
        q_big    = (q_rnd[QW-1:WW-1] != '0);
        q_is_min = (q_rnd == (QW'(1) << (WW - 1)));
        w_sat    = r_neg ? (q_big && !q_is_min) : q_big;
        if (w_sat) begin
            w_val = r_neg ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
        end else if (r_neg) begin
            w_val = -q_rnd[WW-1:0];
        end else begin
            w_val = q_rnd[WW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ali_pkg::WG_IDLE: n_state = ali_pkg::WG_IDLE;
            ali_pkg::WG_LOAD: n_state = s_copy ? ali_pkg::WG_IDLE : ali_pkg::WG_DIV;
            ali_pkg::WG_DIV: begin
                if (r_cnt == ali_pkg::CNT_WIDTH'(QW - 1)) begin
                    n_state = ali_pkg::WG_FIN;
                end
            end
            ali_pkg::WG_FIN:  n_state = ali_pkg::WG_IDLE;
            default:          n_state = ali_pkg::WG_IDLE;
        endcase
        if (wr_hit) begin
            n_state = ali_pkg::WG_LOAD;
        end
    end

    always_comb begin
        load_en = 1'b0;
        div_en  = 1'b0;
        fin_en  = 1'b0;
        case (r_state)
            ali_pkg::WG_LOAD: load_en = 1'b1;
            ali_pkg::WG_DIV:  div_en  = 1'b1;
            ali_pkg::WG_FIN:  fin_en  = 1'b1;
            default: ;
        endcase
        o_busy = (r_state != ali_pkg::WG_IDLE) || wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ali_pkg::WG_IDLE;
            r_wcfg  <= '{weight: '0, copy_mode: 1'b1, swapped: 1'b0,
                         outside: 1'b0, sat: 1'b0};
        end else begin
            r_state <= n_state;
            if (load_en) begin
                r_wcfg <= '{weight: '0, copy_mode: s_copy, swapped: s_swap && !s_copy,
                             outside: s_outside && !s_copy, sat: 1'b0};
            end else if (fin_en) begin
                r_wcfg.weight <= w_val;
                r_wcfg.sat    <= w_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_en) begin
            r_den  <= s_den[AW-1:0];
            r_rem  <= '0;
            r_quot <= {s_mag, {(QW-AW){1'b0}}};
            r_neg  <= s_num[AW];
            r_cnt  <= '0;
        end else if (div_en) begin
            r_rem  <= rem_ge ? rem_diff[AW-1:0] : rem_sh[AW-1:0];
            r_quot <= {r_quot[QW-2:0], rem_ge};
            r_cnt  <= r_cnt + ali_pkg::CNT_WIDTH'(1);
        end
    end

    assign o_wcfg = r_wcfg;

endmodule

// ===== sv/array_linear_interpolator.sv =====
// Array linear interpolator: streaming datapath around the weight generator.
// Depends on ali_pkg and ali_wgen.
//
// Each request on the slave stream carries a left and a right sample of one
// array element; the block returns that element evaluated at the configured
// target abscissa on the master stream, with flags for extrapolation and
// saturation in tuser and tlast passed through.
// The three abscissae are to be written over the register port while the
// stream is idle; the block itself does not enforce this. A write to one
// of them starts a weight recompute: a setup state, the divider state and
// a rounding state, or the setup state alone when the two ends are equal.
// s_axis_tready stays low during the recompute. Throughput is one request per
// cycle while the receiver takes results and no write or recompute is under
// way, set by the three-register pipeline (input, product, result) through
// which a request accepted on the slave stream passes to the master stream.
// Reset clears all valid bits and loads all abscissae with zero, so the block
// starts in copy mode with no recompute pending. When the receiver stalls,
// the result register holds and the pipeline fills its two inner stages
// before s_axis_tready drops.
module array_linear_interpolator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Fields from bit 0: left_sample[15:0], right_sample[31:16].
    input  logic [ali_pkg::IN_TDATA_WIDTH-1:0]    s_axis_tdata,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tlast,
    output logic                                  s_axis_tready,
    // Fields from bit 0: interpolated[15:0].
    output logic [ali_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata,
    // Fields from bit 0: extrapolating[0], clipped[1].
    output logic [ali_pkg::OUT_TUSER_WIDTH-1:0]   m_axis_tuser,
    output logic                                  m_axis_tvalid,
    output logic                                  m_axis_tlast,
    input  logic                                  m_axis_tready,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ali_pkg::CFG_ADDR_WIDTH-1:0]    paddr,
    input  logic [ali_pkg::APB_DATA_WIDTH-1:0]    pwdata,
    output logic [ali_pkg::APB_DATA_WIDTH-1:0]    prdata,
    output logic                                  pready
);

    localparam int S  = ali_pkg::SAMPLE_WIDTH;
    localparam int F  = ali_pkg::WEIGHT_FRAC_BITS;
    localparam int PW = ali_pkg::PROD_WIDTH;
    localparam int AW = ali_pkg::ACC_WIDTH;
    localparam int YW = ali_pkg::YW_WIDTH;
    localparam logic [AW-1:0] HALF = AW'(1) << (F - 1);

    ali_pkg::t_wcfg             wcfg;
    logic                       busy;

    logic                       en_out;
    logic                       en_s2;
    logic                       en_s1;
    logic                       accept;

    logic signed [S-1:0]        in_left;
    logic signed [S-1:0]        in_right;

    logic                       r_s1_valid;
    logic signed [S-1:0]        r_s1_a;
    logic signed [S-1:0]        r_s1_b;
    logic                       r_s1_last;
    logic signed [ali_pkg::DIFF_WIDTH-1:0] s1_diff;
    logic signed [PW-1:0]       s1_prod;

    logic                       r_s2_valid;
    logic signed [PW-1:0]       r_s2_prod;
    logic signed [S-1:0]        r_s2_b;
    logic                       r_s2_last;

    logic signed [AW-1:0]       acc;
    logic signed [AW-1:0]       acc_r;
    logic signed [YW-1:0]       y_wide;
    logic                       y_ovf;
    logic signed [S-1:0]        y_val;
    logic                       y_clip;
    logic                       y_extra;

    logic                       r_out_valid;
    logic signed [S-1:0]        r_out_y;
    logic                       r_out_extra;
    logic                       r_out_clip;
    logic                       r_out_last;

    ali_wgen u_wgen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_busy    (busy),
        .o_wcfg    (wcfg)
    );

    assign pready = 1'b1;

    assign en_out        = !r_out_valid || m_axis_tready;
    assign en_s2         = !r_s2_valid || en_out;
    assign en_s1         = !r_s1_valid || en_s2;
    assign s_axis_tready = en_s1 && !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_left  = s_axis_tdata[S-1:0];
    assign in_right = s_axis_tdata[2*S-1:S];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en_s1) begin
            r_s1_valid <= accept;
        end
    end

    // Ends given in reverse order exchange the samples on the way in.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_a    <= wcfg.swapped ? in_right : in_left;
            r_s1_b    <= wcfg.swapped ? in_left  : in_right;
            r_s1_last <= s_axis_tlast;
        end
    end

    assign s1_diff = {r_s1_a[S-1], r_s1_a} - {r_s1_b[S-1], r_s1_b};
    assign s1_prod = $signed(wcfg.weight) * s1_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en_s2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s2 && r_s1_valid) begin
            r_s2_prod <= s1_prod;
            r_s2_b    <= r_s1_b;
            r_s2_last <= r_s1_last;
        end
    end

    // Rounding to nearest with ties away from zero: add half, less one when negative.
    always_comb begin
        acc     = {{(AW-S-F){r_s2_b[S-1]}}, r_s2_b, {F{1'b0}}}
                + {{(AW-PW){r_s2_prod[PW-1]}}, r_s2_prod};
        acc_r   = acc + HALF - AW'(acc[AW-1]);
        y_wide  = acc_r[AW-1:F];
        y_ovf   = (y_wide[YW-1:S-1] != '0) && (y_wide[YW-1:S-1] != '1);
        y_extra = 1'b0;
        y_clip  = 1'b0;
        if (wcfg.copy_mode) begin
            y_val = r_s2_b;
        end else begin
            y_extra = wcfg.outside;
            y_clip  = wcfg.sat || y_ovf;
            if (y_ovf) begin
                y_val = y_wide[YW-1] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
            end else begin
                y_val = y_wide[S-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_s2_valid) begin
            r_out_y     <= y_val;
            r_out_extra <= y_extra;
            r_out_clip  <= y_clip;
            r_out_last  <= r_s2_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = ali_pkg::OUT_TDATA_WIDTH'($unsigned(r_out_y));
    assign m_axis_tlast  = r_out_last;
    always_comb begin
        m_axis_tuser                       = '0;
        m_axis_tuser[ali_pkg::TUSER_EXTRAP] = r_out_extra;
        m_axis_tuser[ali_pkg::TUSER_CLIP]   = r_out_clip;
    end

endmodule

// ===== sv/ali_checker.sv =====
// Port-level checker for the array linear interpolator, bound to the top level.
// Depends on ali_pkg and array_linear_interpolator_assert.svh.
`include "array_linear_interpolator_assert.svh"

module ali_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic [ali_pkg::OUT_TDATA_WIDTH-1:0]   m_axis_tdata,
    input logic [ali_pkg::OUT_TUSER_WIDTH-1:0]   m_axis_tuser,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tlast,
    input logic                                  m_axis_tready,
    input logic                                  psel,
    input logic                                  penable,
    input logic                                  pwrite,
    input logic                                  pready
);

    // A stalled result keeps its contents.
    `ALI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // Requests are held off during the access cycle of any register write.
    `ALI_ASSERT_IMP(a_cfg_blocks, i_clk, i_rst_n, psel && penable && pwrite && pready, !s_axis_tready)

    // A new result appears only for a request the slave stream took earlier.
    `ALI_ASSERT_IMP(a_out_latency, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 3))

endmodule

bind array_linear_interpolator ali_checker u_ali_checker (.*);
